// ===== src/prosign_digraph_substitution_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the prosign digraph substitution block
// Immediate-style wrappers around concurrent implication checks; empty when
// SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef PROSIGN_DIGRAPH_SUBSTITUTION_MACROS_SVH
`define PROSIGN_DIGRAPH_SUBSTITUTION_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define PDS_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle check");
// next-cycle implication
`define PDS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle check");
`else
`define PDS_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define PDS_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ===== src/pdsub_pkg.sv =====
// ---------------------------------------------------------------------------
// Prosign digraph substitution package
// Character types, code characters and the digraph lookup.
// ---------------------------------------------------------------------------
package pdsub_pkg;

   typedef logic [7:0] char_type;

   typedef struct packed {
      logic     hit;
      char_type code;
   } dg_type;

   // one decision: up to three result characters, cnt == 0 means none
   typedef struct packed {
      logic       eom;
      logic [1:0] cnt;
      char_type   c2;
      char_type   c1;
      char_type   c0;
   } group_type;

   localparam char_type CODE_SOS = 8'h5C;   // backslash
   localparam char_type CODE_AA  = 8'h7E;   // ~
   localparam char_type CODE_AR  = 8'h5E;   // ^
   localparam char_type CODE_AS  = 8'h3C;   // <
   localparam char_type CODE_BK  = 8'h3E;   // >
   localparam char_type CODE_BT  = 8'h5B;   // [
   localparam char_type CODE_CL  = 8'h5D;   // ]
   localparam char_type CODE_CT  = 8'h7B;   // {
   localparam char_type CODE_DO  = 8'h7D;   // }
   localparam char_type CODE_HH  = 8'h23;   // #
   localparam char_type CODE_KA  = 8'h2A;   // *
   localparam char_type CODE_KN  = 8'h24;   // $
   localparam char_type CODE_SK  = 8'h7C;   // |
   localparam char_type CODE_SN  = 8'h5F;   // _

   localparam char_type CHAR_LC_A  = 8'h61;
   localparam char_type CHAR_LC_Z  = 8'h7A;
   localparam char_type CASE_DELTA = 8'h20;
   localparam char_type CHAR_S     = 8'h53;
   localparam char_type CHAR_O     = 8'h4F;

   function automatic char_type fold_upper(input char_type c);
      if (c >= CHAR_LC_A && c <= CHAR_LC_Z) begin
         return c - CASE_DELTA;
      end
      return c;
   endfunction

   function automatic dg_type digraph_code(input char_type a, input char_type b);
      dg_type r;
      r.hit = 1'b1;
      unique case ({a, b})
         "AA":    r.code = CODE_AA;
         "AR":    r.code = CODE_AR;
         "AS":    r.code = CODE_AS;
         "BK":    r.code = CODE_BK;
         "BT":    r.code = CODE_BT;
         "CL":    r.code = CODE_CL;
         "CT":    r.code = CODE_CT;
         "DO":    r.code = CODE_DO;
         "HH":    r.code = CODE_HH;
         "KA":    r.code = CODE_KA;
         "KN":    r.code = CODE_KN;
         "SK":    r.code = CODE_SK;
         "SN":    r.code = CODE_SN;
         default: begin
            r.hit  = 1'b0;
            r.code = '0;
         end
      endcase
      return r;
   endfunction

   function automatic logic is_sos(input char_type a, input char_type b, input char_type c);
      return (a == CHAR_S) && (b == CHAR_O) && (c == CHAR_S);
   endfunction

endpackage

// ===== src/pdsub_match.sv =====
// ---------------------------------------------------------------------------
// Prosign digraph substitution matcher
// Greedy window decision: result characters and the next pending state.
// ---------------------------------------------------------------------------
module pdsub_match
   import pdsub_pkg::*;
(
   input  char_type   pend0,
   input  char_type   pend1,
   input  logic [1:0] pend_cnt,
   input  char_type   chr,
   input  logic       eom,
   output group_type  grp,
   output char_type   next_pend0,
   output char_type   next_pend1,
   output logic [1:0] next_cnt
);

   char_type   w0;
   char_type   w1;
   char_type   w2;
   logic [1:0] n;
   dg_type     d01;
   dg_type     d12;
   logic       sos;

   always_comb begin
      w0  = (pend_cnt == 2'd0) ? chr : pend0;
      w1  = (pend_cnt == 2'd1) ? chr : pend1;
      w2  = chr;
      n   = pend_cnt + 2'd1;
      d01 = digraph_code(w0, w1);
      d12 = digraph_code(w1, w2);
      sos = is_sos(w0, w1, w2);
   end

   always_comb begin
      grp        = '0;
      next_pend0 = pend0;
      next_pend1 = pend1;
      next_cnt   = pend_cnt;
      if (!eom) begin
         priority if (n != 2'd3) begin
            // window not full yet: hold everything
            next_pend0 = w0;
            next_pend1 = w1;
            next_cnt   = n;
         end else if (sos) begin
            grp.cnt = 2'd1;
            grp.c0  = CODE_SOS;
            next_cnt = 2'd0;
         end else if (d01.hit) begin
            grp.cnt    = 2'd1;
            grp.c0     = d01.code;
            next_pend0 = w2;
            next_cnt   = 2'd1;
         end else begin
            grp.cnt    = 2'd1;
            grp.c0     = w0;
            next_pend0 = w1;
            next_pend1 = w2;
            next_cnt   = 2'd2;
         end
      end else begin
         // flush the whole window with the lookahead that remains
         grp.eom  = 1'b1;
         next_cnt = 2'd0;
         priority if (n == 2'd3 && sos) begin
            grp.cnt = 2'd1;
            grp.c0  = CODE_SOS;
         end else if (n != 2'd1 && d01.hit) begin
            grp.c0  = d01.code;
            grp.c1  = w2;
            grp.cnt = (n == 2'd3) ? 2'd2 : 2'd1;
         end else begin
            grp.c0 = w0;
            priority if (n == 2'd1) begin
               grp.cnt = 2'd1;
            end else if (n == 2'd2) begin
               grp.c1  = w1;
               grp.cnt = 2'd2;
            end else if (d12.hit) begin
               grp.c1  = d12.code;
               grp.cnt = 2'd2;
            end else begin
               grp.c1  = w1;
               grp.c2  = w2;
               grp.cnt = 2'd3;
            end
         end
      end
   end

endmodule

// ===== src/pdsub_window.sv =====
// ---------------------------------------------------------------------------
// Prosign digraph substitution input window
// Input register, pending characters and the decision for each item.
// ---------------------------------------------------------------------------
`include "prosign_digraph_substitution_macros.svh"

module pdsub_window
   import pdsub_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  char_type  in_char,
   input  logic      in_eom,
   input  logic      grp_free,
   output logic      grp_load,
   output group_type grp
);

   logic       s1_valid_ff, s1_valid_in;
   char_type   s1_char_ff;
   logic       s1_eom_ff;
   char_type   pend0_ff, pend0_in;
   char_type   pend1_ff, pend1_in;
   logic [1:0] pend_cnt_ff, pend_cnt_in;
   logic       advance;

   pdsub_match u_match (
      .pend0      (pend0_ff),
      .pend1      (pend1_ff),
      .pend_cnt   (pend_cnt_ff),
      .chr        (s1_char_ff),
      .eom        (s1_eom_ff),
      .grp        (grp),
      .next_pend0 (pend0_in),
      .next_pend1 (pend1_in),
      .next_cnt   (pend_cnt_in)
   );

   // an item that emits nothing needs no room downstream
   assign advance  = s1_valid_ff && (grp_free || grp.cnt == 2'd0);
   assign grp_load = advance && (grp.cnt != 2'd0);
   assign in_ready = !s1_valid_ff || advance;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (in_ready) begin
         s1_valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         pend_cnt_ff <= 2'd0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (advance) begin
            pend_cnt_ff <= pend_cnt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         s1_char_ff <= fold_upper(in_char);
         s1_eom_ff  <= in_eom;
      end
      if (advance) begin
         pend0_ff <= pend0_in;
         pend1_ff <= pend1_in;
      end
   end

   `PDS_ASSERT_IMPL(a_pend_cnt_range, clock, reset, 1'b1, pend_cnt_ff != 2'd3)
   `PDS_ASSERT_IMPL(a_mid_single, clock, reset, s1_valid_ff && !s1_eom_ff, grp.cnt < 2'd2)
   `PDS_ASSERT_NEXT(a_eom_clears, clock, reset, advance && s1_eom_ff, pend_cnt_ff == 2'd0)

endmodule

// ===== src/pdsub_out.sv =====
// ---------------------------------------------------------------------------
// Prosign digraph substitution output stage
// Result register holding one decision; drains its characters one per cycle while out_ready is high.
// ---------------------------------------------------------------------------
`include "prosign_digraph_substitution_macros.svh"

module pdsub_out
   import pdsub_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      grp_load,
   input  group_type grp,
   output logic      grp_free,
   output logic      out_valid,
   input  logic      out_ready,
   output char_type  out_char,
   output logic      out_last
);

   logic       valid_ff, valid_in;
   logic [1:0] idx_ff, idx_in;
   group_type  grp_ff;
   logic       final_one;
   logic       pop;

   assign final_one = (idx_ff == grp_ff.cnt - 2'd1);
   assign pop       = valid_ff && out_ready;
   assign grp_free  = !valid_ff || (pop && final_one);

   assign out_valid = valid_ff;
   assign out_last  = grp_ff.eom && final_one;

   always_comb begin
      unique case (idx_ff)
         2'd0:    out_char = grp_ff.c0;
         2'd1:    out_char = grp_ff.c1;
         default: out_char = grp_ff.c2;
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (grp_load) begin
         valid_in = 1'b1;
         idx_in   = 2'd0;
      end else if (pop) begin
         if (final_one) begin
            valid_in = 1'b0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (grp_load) begin
         grp_ff <= grp;
      end
   end

   `PDS_ASSERT_IMPL(a_idx_in_group, clock, reset, valid_ff, grp_ff.cnt != 2'd0 && idx_ff < grp_ff.cnt)
   `PDS_ASSERT_IMPL(a_load_when_free, clock, reset, grp_load, grp_free)

endmodule

// ===== src/prosign_digraph_substitution.sv =====
// ---------------------------------------------------------------------------
// Prosign digraph substitution
// Streams message characters and replaces SOS and prosign digraphs by codes.
// ---------------------------------------------------------------------------
// Each req item carries one character and an end-of-message flag. Lowercase
// a-z is folded to uppercase; the block keeps up to two pending characters
// and decides greedily over a three-character window: SOS becomes a
// backslash, one of the thirteen digraphs (AA AR AS BK BT CL CT DO HH KA KN
// SK SN) becomes its code character, anything else passes through. Inside a
// message an item yields at most one rsp item, and the first two items of a
// message yield none; the item with req_tlast flushes the window and yields
// one to three rsp items, the last of them with rsp_tlast set. An accepted
// item passes through the input register, then the window decision into the
// result register. One item per cycle is sustained while the output keeps
// up; a flush loads up to three results, and the result register drains its
// characters one per cycle while rsp_tready is high; a later item that has a
// result waits until the register is free.
// ---------------------------------------------------------------------------
module prosign_digraph_substitution
   import pdsub_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,    // [7:0] char_in
   input  logic       req_tlast,    // end_of_message
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,    // [7:0] char_out
   output logic       rsp_tlast     // last_out
);

   logic      grp_free;
   logic      grp_load;
   group_type grp;

   // input register, pending window and decision
   pdsub_window u_window (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_char  (req_tdata),
      .in_eom   (req_tlast),
      .grp_free (grp_free),
      .grp_load (grp_load),
      .grp      (grp)
   );

   // result register; drain a decision one character at a time
   pdsub_out u_out (
      .clock     (clock),
      .reset     (reset),
      .grp_load  (grp_load),
      .grp       (grp),
      .grp_free  (grp_free),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_char  (rsp_tdata),
      .out_last  (rsp_tlast)
   );

endmodule

// ===== test/prosign_digraph_substitution_tb.sv =====
// ---------------------------------------------------------------------------
// Prosign digraph substitution testbench
// Streams messages into the block, predicts each output character from a
// local copy of the lookahead window and compares every rsp item in order.
// ---------------------------------------------------------------------------
// A monitor predicts results on each accepted req item and checks each
// accepted rsp item against the oldest prediction. Both sides insert random
// gaps: mostly short, a few long, with stretches of back-to-back traffic.
// A watchdog ends the run when nothing moves for too long.
// ---------------------------------------------------------------------------
module prosign_digraph_substitution_tb;
   import pdsub_pkg::*;

   localparam int IDLE_LIMIT   = 2000;  // cycles without any handshake
   localparam int DRAIN_CYCLES = 6;     // extra wait after the queue empties

   typedef struct {
      char_type ch;
      logic     last;
   } out_char_type;

   logic       clock;
   logic       reset       = 1'b1;
   logic       req_tvalid  = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata   = '0;   // [7:0] char_in
   logic       req_tlast   = 1'b0; // end_of_message
   logic       rsp_tvalid;
   logic       rsp_tready  = 1'b0;
   logic [7:0] rsp_tdata;          // [7:0] char_out
   logic       rsp_tlast;          // last_out

   // predictor state: characters waiting for lookahead, already uppercased
   char_type     pend_chars [2] = '{8'h00, 8'h00};
   int unsigned  pend_count     = 0;
   out_char_type expected_chars [$];

   int  mismatch_count = 0;
   int  idle_cycles    = 0;
   int  rsp_stall      = 0;
   bit  steady         = 1'b0;   // suppress gaps on both sides

   prosign_digraph_substitution dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Pick a gap length: half none, most short, a few long.
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic char_type to_upper(input char_type c);
      if (c >= "a" && c <= "z") return c - 8'd32;
      return c;
   endfunction

   // Look up a prosign pair; returns 1 and the code character on a hit.
   function automatic bit pair_code(input char_type a, input char_type b,
                                    output char_type code);
      code = '0;
      case (a)
         "A": case (b)
               "A": code = CODE_AA;
               "R": code = CODE_AR;
               "S": code = CODE_AS;
               default: ;
            endcase
         "B": case (b)
               "K": code = CODE_BK;
               "T": code = CODE_BT;
               default: ;
            endcase
         "C": case (b)
               "L": code = CODE_CL;
               "T": code = CODE_CT;
               default: ;
            endcase
         "D": if (b == "O") code = CODE_DO;
         "H": if (b == "H") code = CODE_HH;
         "K": case (b)
               "A": code = CODE_KA;
               "N": code = CODE_KN;
               default: ;
            endcase
         "S": case (b)
               "K": code = CODE_SK;
               "N": code = CODE_SN;
               default: ;
            endcase
         default: ;
      endcase
      return code != '0;
   endfunction

   function automatic void push_char(input char_type c, input logic last);
      out_char_type e;
      e.ch   = c;
      e.last = last;
      expected_chars.push_back(e);
   endfunction

   // Advance the window by one accepted character and queue what it emits.
   function automatic void substitute_char(input char_type c_in, input logic eom);
      char_type    win [3];
      char_type    code;
      int unsigned n;
      int unsigned pos;
      win[0] = pend_chars[0];
      win[1] = pend_chars[1];
      win[2] = '0;
      n = pend_count;
      win[n] = to_upper(c_in);
      n++;
      if (!eom) begin
         if (n < 3) begin
            // hold: not enough lookahead yet
            pend_chars[0] = win[0];
            pend_chars[1] = win[1];
            pend_count    = n;
         end else if (win[0] == "S" && win[1] == "O" && win[2] == "S") begin
            push_char(CODE_SOS, 1'b0);
            pend_count = 0;
         end else if (pair_code(win[0], win[1], code)) begin
            push_char(code, 1'b0);
            pend_chars[0] = win[2];
            pend_count    = 1;
         end else begin
            push_char(win[0], 1'b0);
            pend_chars[0] = win[1];
            pend_chars[1] = win[2];
            pend_count    = 2;
         end
      end else begin
         // flush with whatever lookahead remains
         pos = 0;
         while (pos < n) begin
            if (n - pos >= 3 && win[pos] == "S" && win[pos+1] == "O" && win[pos+2] == "S") begin
               pos += 3;
               push_char(CODE_SOS, pos >= n);
            end else if (n - pos >= 2 && pair_code(win[pos], win[pos+1], code)) begin
               pos += 2;
               push_char(code, pos >= n);
            end else begin
               pos += 1;
               push_char(win[pos-1], pos >= n);
            end
         end
         pend_count = 0;
      end
   endfunction

   // Receiver: stall at random unless a steady stretch is running.
   always @(posedge clock) begin
      if (steady) rsp_stall = 0;
      else if (rsp_stall == 0) rsp_stall = gap_len();
      if (rsp_stall > 0) begin
         rsp_tready <= 1'b0;
         rsp_stall--;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Monitor: predict on req items, check rsp items, watch for a hang.
   always @(posedge clock) begin
      out_char_type e;
      if (reset) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (req_tvalid && req_tready) begin
            substitute_char(req_tdata, req_tlast);
            idle_cycles = 0;
         end
         if (rsp_tvalid && rsp_tready) begin
            idle_cycles = 0;
            if (expected_chars.size() == 0) begin
               $display("%0t: unexpected rsp item char=%02h last=%0b",
                        $time, rsp_tdata, rsp_tlast);
               mismatch_count++;
            end else begin
               e = expected_chars.pop_front();
               if (rsp_tdata !== e.ch) begin
                  $display("%0t: char_out mismatch, expected %02h actual %02h",
                           $time, e.ch, rsp_tdata);
                  mismatch_count++;
               end
               if (rsp_tlast !== e.last) begin
                  $display("%0t: last_out mismatch, expected %0b actual %0b",
                           $time, e.last, rsp_tlast);
                  mismatch_count++;
               end
            end
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: timeout, no handshake for %0d cycles", $time, IDLE_LIMIT);
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // Send one item; valid stays high into the next item when there is no gap.
   task automatic send_char(input char_type c, input logic eom);
      int gap;
      gap = steady ? 0 : gap_len();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= eom;
      do @(posedge clock); while (!req_tready);
   endtask

   // Send an ASCII string; mark its last character as end of message if asked.
   task automatic send_string(input string s, input bit close_it);
      for (int i = 0; i < s.len(); i++) begin
         send_char(s[i], close_it && (i == s.len() - 1));
      end
   endtask

   // Let the monitor record the last accepted item, then wait for its results.
   task automatic wait_drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Draw a character biased toward prosign letters in either case.
   function automatic char_type pick_char();
      string    hot;
      char_type c;
      int       r;
      hot = "SOAKRBTCLDHN";
      r = $urandom_range(0, 99);
      if (r < 70) begin
         c = hot[$urandom_range(0, hot.len() - 1)];
         if ($urandom_range(0, 2) == 0) c = c | 8'h20;
      end else if (r < 85) begin
         c = 8'($urandom_range("A", "Z"));
         if ($urandom_range(0, 1) == 0) c = c | 8'h20;
      end else begin
         c = 8'($urandom_range(0, 255));
      end
      return c;
   endfunction

   // Corner messages: single and two-character flushes, SOS in both forms,
   // every case-fold boundary, high and zero bytes.
   task automatic test_directed();
      send_char("x", 1'b1);
      send_char(8'h00, 1'b0);
      send_char(8'hFF, 1'b1);
      send_string("sos", 1'b1);
      send_string("SOSa", 1'b1);
      send_string("aRbtKnz", 1'b1);
      send_char(8'h60, 1'b0);    // just below lowercase a
      send_string("{sk", 1'b1);
      send_char(8'h80, 1'b0);
      send_string("aa", 1'b1);
      wait_drain();
   endtask

   // Well-formed messages of random length made mostly of prosign letters.
   task automatic test_prosign_messages(input int item_goal);
      int sent;
      int len;
      sent = 0;
      while (sent < item_goal) begin
         steady = ($urandom_range(0, 4) == 0);
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8);
         for (int i = 0; i < len; i++) begin
            send_char(pick_char(), i == len - 1);
         end
         sent += len;
      end
      steady = 1'b0;
      wait_drain();
   endtask

   // Uniform random bytes with end-of-message flags at random.
   task automatic test_random_bytes(input int items);
      for (int i = 0; i < items; i++) begin
         if (i % 25 == 0) steady = ($urandom_range(0, 3) == 0);
         send_char(8'($urandom_range(0, 255)),
                   (i == items - 1) || ($urandom_range(0, 5) == 0));
      end
      steady = 1'b0;
      wait_drain();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_prosign_messages(210);
      test_random_bytes(90);
      if (mismatch_count == 0 && expected_chars.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+src
src/pdsub_pkg.sv
src/pdsub_match.sv
src/pdsub_window.sv
src/pdsub_out.sv
src/prosign_digraph_substitution.sv
test/prosign_digraph_substitution_tb.sv
